// ===== hw/rtl/bgnt_pkg.sv =====
// ----------------------------------------------------------------------------
// bgnt_pkg
// Shared sizes, register map, reset values and item types of the beam grid
// note trigger.
// ----------------------------------------------------------------------------
`default_nettype none

package bgnt_pkg;

  localparam int BEAMS   = 8;
  localparam int SCALES  = 4;
  localparam int IDX_W   = $clog2(BEAMS);
  localparam int SCALE_W = (SCALES > 1) ? $clog2(SCALES) : 1;
  localparam int TBL_DEPTH = SCALES * BEAMS * BEAMS;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);

  // register map (index = paddr / 4)
  localparam logic [1:0] REG_SCALE_SELECT   = 2'd0;
  localparam logic [1:0] REG_HOLD_MS        = 2'd1;
  localparam logic [1:0] REG_PRESS_VELOCITY = 2'd2;
  localparam logic [1:0] REG_EVENT_CHANNEL  = 2'd3;

  localparam logic [1:0]  RST_SCALE_SELECT   = 2'd0;
  localparam logic [15:0] RST_HOLD_MS        = 16'd100;
  localparam logic [6:0]  RST_PRESS_VELOCITY = 7'd127;
  localparam logic [3:0]  RST_EVENT_CHANNEL  = 4'd0;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_WRITE  = 1'b1;

  typedef struct packed {
    logic [1:0]  scale_select;
    logic [15:0] hold_ms;
    logic [6:0]  press_velocity;
    logic [3:0]  event_channel;
  } cfg_t;

  // classified item between front and back
  typedef struct packed {
    logic              mode;
    logic [BEAMS-1:0]  x_bits;
    logic [BEAMS-1:0]  y_bits;
    logic              x_one;
    logic [IDX_W-1:0]  x_idx;
    logic              y_one;
    logic [IDX_W-1:0]  y_idx;
    logic [31:0]       now_ms;
    logic              wr_ok;
    logic [TBL_AW-1:0] wr_addr;
    logic [7:0]        wr_note;
  } item_t;

  typedef struct packed {
    logic [6:0] note;
    logic [6:0] velocity;
    logic [3:0] channel;
    logic       last;
  } ev_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bgnt_front.sv =====
// ----------------------------------------------------------------------------
// bgnt_front
// Classifies an input item: masks the beams, finds a single broken beam per
// axis and forms the table write address.
// ----------------------------------------------------------------------------
`default_nettype none

module bgnt_front (
  input  logic                 mode,
  input  logic [7:0]           x_beams,
  input  logic [7:0]           y_beams,
  input  logic [31:0]          now_ms,
  input  logic [1:0]           entry_scale,
  input  logic [2:0]           entry_x,
  input  logic [2:0]           entry_y,
  input  logic signed [7:0]    entry_note,
  output bgnt_pkg::item_t      item
);
  import bgnt_pkg::*;

  logic [BEAMS-1:0] xb, yb;
  logic [IDX_W-1:0] xi, yi;

  assign xb = x_beams[BEAMS-1:0];
  assign yb = y_beams[BEAMS-1:0];

  // index is valid only when exactly one bit is set
  always_comb begin
    xi = '0;
    yi = '0;
    for (int i = 0; i < BEAMS; i++) begin
      if (xb[i]) xi = xi | IDX_W'(i);
      if (yb[i]) yi = yi | IDX_W'(i);
    end
  end

  always_comb begin
    item.mode    = mode;
    item.x_bits  = xb;
    item.y_bits  = yb;
    item.x_one   = (xb != '0) && ((xb & (xb - 1'b1)) == '0);
    item.x_idx   = xi;
    item.y_one   = (yb != '0) && ((yb & (yb - 1'b1)) == '0);
    item.y_idx   = yi;
    item.now_ms  = now_ms;
    item.wr_ok   = (32'(entry_x) < BEAMS) && (32'(entry_y) < BEAMS);
    item.wr_addr = {entry_scale[SCALE_W-1:0], entry_y[IDX_W-1:0], entry_x[IDX_W-1:0]};
    item.wr_note = entry_note;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bgnt_queue.sv =====
// ----------------------------------------------------------------------------
// bgnt_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module bgnt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  bgnt_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output bgnt_pkg::item_t pop_item
);
  import bgnt_pkg::*;

  item_t      slot [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = slot[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) slot[wptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop)  rptr <= ~rptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bgnt_back.sv =====
// ----------------------------------------------------------------------------
// bgnt_back
// Executes classified items: table writes, hold check, position tracking,
// table lookup and note events into a small event queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bgnt_back (
  input  logic            clk,
  input  logic            rst,
  input  bgnt_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  bgnt_pkg::item_t in_item,
  output logic            ev_valid,
  input  logic            ev_ready,
  output bgnt_pkg::ev_t   ev
);
  import bgnt_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic state, state_next;

  logic [7:0] note_table [TBL_DEPTH];
  logic [7:0] rd_data;

  logic             held_xv, held_yv;
  logic [IDX_W-1:0] held_x, held_y;
  logic [6:0]       held_note;
  logic             note_sounding;
  logic [31:0]      press_time;

  // decision latched for the lookup cycle
  logic        pos_valid;
  logic [31:0] cur_time;

  // event queue
  ev_t        evq [4];
  logic [1:0] ev_wptr, ev_rptr;
  logic [2:0] ev_count;

  logic             take, blocked, changed;
  logic             nxv, nyv;
  logic [IDX_W-1:0] nx, ny;
  logic             new_on;
  logic [1:0]       n_push;
  ev_t              ev_rel, ev_press, ev_first;
  logic             ev_pop;

  assign in_ready = (state == ST_IDLE);
  assign take     = in_valid && in_ready;

  always_comb begin
    blocked = note_sounding && ((in_item.now_ms - press_time) < {16'd0, cfg.hold_ms});
    if (held_xv && in_item.x_bits[held_x]) begin
      nxv = 1'b1; nx = held_x;
    end else begin
      nxv = in_item.x_one; nx = in_item.x_idx;
    end
    if (held_yv && in_item.y_bits[held_y]) begin
      nyv = 1'b1; ny = held_y;
    end else begin
      nyv = in_item.y_one; ny = in_item.y_idx;
    end
    changed = !blocked && (nxv == nyv)
              && !((nxv == held_xv) && (nyv == held_yv)
                   && (!nxv || (nx == held_x)) && (!nyv || (ny == held_y)));
  end

  // table write and registered lookup
  always_ff @(posedge clk) begin
    if (take && in_item.mode == MODE_WRITE && in_item.wr_ok)
      note_table[in_item.wr_addr] <= in_item.wr_note;
    if (take && in_item.mode == MODE_SAMPLE)
      rd_data <= note_table[{cfg.scale_select[SCALE_W-1:0], ny, nx}];
  end

  always_comb begin
    new_on = pos_valid && !rd_data[7];
    ev_rel.note       = held_note;
    ev_rel.velocity   = 7'd0;
    ev_rel.channel    = cfg.event_channel;
    ev_rel.last       = !new_on;
    ev_press.note     = rd_data[6:0];
    ev_press.velocity = cfg.press_velocity;
    ev_press.channel  = cfg.event_channel;
    ev_press.last     = 1'b1;
    ev_first = note_sounding ? ev_rel : ev_press;
    n_push   = {1'b0, note_sounding} + {1'b0, new_on};
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (take && in_item.mode == MODE_SAMPLE && changed) state_next = ST_LOOK;
      ST_LOOK: if (ev_count <= 3'd2) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign ev_valid = (ev_count != 3'd0);
  assign ev       = evq[ev_rptr];
  assign ev_pop   = ev_valid && ev_ready;

  always_ff @(posedge clk) begin
    if (state == ST_LOOK && ev_count <= 3'd2) begin
      if (n_push != 2'd0) evq[ev_wptr] <= ev_first;
      if (n_push == 2'd2) evq[ev_wptr + 2'd1] <= ev_press;
    end
    if (take) begin
      pos_valid <= nxv;
      cur_time  <= in_item.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      held_xv       <= 1'b0;
      held_yv       <= 1'b0;
      held_x        <= '0;
      held_y        <= '0;
      held_note     <= 7'd0;
      note_sounding <= 1'b0;
      press_time    <= 32'd0;
      ev_wptr       <= 2'd0;
      ev_rptr       <= 2'd0;
      ev_count      <= 3'd0;
    end else begin
      state <= state_next;
      if (take && in_item.mode == MODE_SAMPLE && changed) begin
        held_xv <= nxv;
        held_yv <= nyv;
        held_x  <= nx;
        held_y  <= ny;
      end
      if (state == ST_LOOK && ev_count <= 3'd2) begin
        note_sounding <= new_on;
        if (new_on) begin
          held_note  <= rd_data[6:0];
          press_time <= cur_time;
        end
        ev_wptr  <= ev_wptr + n_push;
        ev_count <= ev_count + {1'b0, n_push} - {2'b0, ev_pop};
      end else begin
        ev_count <= ev_count - {2'b0, ev_pop};
      end
      if (ev_pop) ev_rptr <= ev_rptr + 2'd1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/beam_grid_note_trigger_core.sv =====
// ----------------------------------------------------------------------------
// beam_grid_note_trigger_core
// Light beam grid played as a note trigger: tracks the broken x/y beam,
// looks up the note of the grid position and sends release/press events.
// ----------------------------------------------------------------------------
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------------------
//   input    | in_valid/in_ready  | mode x_beams y_beams now_ms entry_* fields
//   result   | out_valid/out_ready| note velocity channel last
//   config   | APB psel/penable   | paddr pwdata prdata pready (always high)
//
// The front classifies an item in the cycle it is accepted and hands it to a
// two-entry queue. The back takes a table write, or a sample that leaves the
// position unchanged, in its idle state; a sample that changes the position
// then enters a lookup state for the registered read of the note table, and
// no new item is taken until it is left. Up to two events per sample go into
// a four-entry event queue; the lookup state holds while fewer than two
// entries are free. Synchronous reset clears all control state; the note
// table holds undefined data until written.
`default_nettype none

module beam_grid_note_trigger_core (
  input  logic             clk,
  input  logic             rst,
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // input items
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             mode,
  input  logic [7:0]       x_beams,
  input  logic [7:0]       y_beams,
  input  logic [31:0]      now_ms,
  input  logic [1:0]       entry_scale,
  input  logic [2:0]       entry_x,
  input  logic [2:0]       entry_y,
  input  logic signed [7:0] entry_note,
  // result items
  output logic             out_valid,
  input  logic             out_ready,
  output logic [6:0]       note,
  output logic [6:0]       velocity,
  output logic [3:0]       channel,
  output logic             last
);
  import bgnt_pkg::*;

  cfg_t       cfg;
  logic [1:0] reg_idx;
  logic       cfg_wr;
  item_t      front_item, back_item;
  logic       q_valid, q_ready;
  ev_t        ev;

  // register file: write on the access phase of an APB transfer
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_select   <= RST_SCALE_SELECT;
      cfg.hold_ms        <= RST_HOLD_MS;
      cfg.press_velocity <= RST_PRESS_VELOCITY;
      cfg.event_channel  <= RST_EVENT_CHANNEL;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SCALE_SELECT:   cfg.scale_select   <= pwdata[1:0];
        REG_HOLD_MS:        cfg.hold_ms        <= pwdata[15:0];
        REG_PRESS_VELOCITY: cfg.press_velocity <= pwdata[6:0];
        REG_EVENT_CHANNEL:  cfg.event_channel  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SCALE_SELECT:   prdata = {30'd0, cfg.scale_select};
      REG_HOLD_MS:        prdata = {16'd0, cfg.hold_ms};
      REG_PRESS_VELOCITY: prdata = {25'd0, cfg.press_velocity};
      REG_EVENT_CHANNEL:  prdata = {28'd0, cfg.event_channel};
      default:            prdata = 32'd0;
    endcase
  end

  // classify the incoming item
  bgnt_front u_front (
    .mode        (mode),
    .x_beams     (x_beams),
    .y_beams     (y_beams),
    .now_ms      (now_ms),
    .entry_scale (entry_scale),
    .entry_x     (entry_x),
    .entry_y     (entry_y),
    .entry_note  (entry_note),
    .item        (front_item)
  );

  // decouple acceptance from execution
  bgnt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (front_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (back_item)
  );

  // execute items and queue the note events
  bgnt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (q_valid),
    .in_ready (q_ready),
    .in_item  (back_item),
    .ev_valid (out_valid),
    .ev_ready (out_ready),
    .ev       (ev)
  );

  assign note     = ev.note;
  assign velocity = ev.velocity;
  assign channel  = ev.channel;
  assign last     = ev.last;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for beam_grid_note_trigger_core. Drives sensor samples
// and note table writes over the valid/ready input channel and the registers
// over APB. A scoreboard tracks the beam position, hold timer and table, and
// it matches every release/press event on the result channel in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bgnt_pkg::*;

  localparam int NO_BEAM      = -1;
  localparam int SETTLE       = 12;    // cycles for a queued no-event item to drain
  localparam int QUIET_LIMIT  = 3000;  // cycles without any transfer before giving up

  typedef struct {
    bit        mode;
    bit [7:0]  xb;
    bit [7:0]  yb;
    bit [31:0] now;
    bit [1:0]  es;
    bit [2:0]  ex;
    bit [2:0]  ey;
    bit [7:0]  en;
  } beam_item_t;

  typedef struct {
    bit [6:0] note;
    bit [6:0] velocity;
    bit [3:0] channel;
    bit       last;
  } note_event_t;

  // Tracks the grid position, the sounding note and the note table, and
  // holds the events that the block still owes.
  class grid_scoreboard;
    bit [1:0]    scale_sel;
    bit [15:0]   hold;
    bit [6:0]    press_vel;
    bit [3:0]    chan;
    int          held_x;
    int          held_y;
    bit [6:0]    held_note;
    bit          sounding;
    bit [31:0]   press_time;
    bit [7:0]    notes [TBL_DEPTH];
    bit          written [TBL_DEPTH];
    note_event_t owed_events [$];
    int          errors;

    function new();
      scale_sel  = RST_SCALE_SELECT;
      hold       = RST_HOLD_MS;
      press_vel  = RST_PRESS_VELOCITY;
      chan       = RST_EVENT_CHANNEL;
      held_x     = NO_BEAM;
      held_y     = NO_BEAM;
      held_note  = 0;
      sounding   = 0;
      press_time = 0;
      errors     = 0;
      foreach (written[i]) written[i] = 0;
    endfunction

    function void set_reg(bit [1:0] idx, bit [31:0] val);
      case (idx)
        REG_SCALE_SELECT:   scale_sel = val[1:0];
        REG_HOLD_MS:        hold      = val[15:0];
        REG_PRESS_VELOCITY: press_vel = val[6:0];
        REG_EVENT_CHANNEL:  chan      = val[3:0];
        default: ;
      endcase
    endfunction

    // Keep the held beam while it stays broken, else take the single one.
    function int beam_index(bit [7:0] bits, int prev);
      int found;
      int count;
      found = NO_BEAM;
      count = 0;
      if (prev >= 0 && bits[prev]) return prev;
      for (int i = 0; i < BEAMS; i++) begin
        if (bits[i]) begin
          found = i;
          count++;
        end
      end
      return (count == 1) ? found : NO_BEAM;
    endfunction

    function int table_addr(int scale, int x, int y);
      return ((scale % SCALES) * BEAMS + y) * BEAMS + x;
    endfunction

    // True when a sample moves the position; the new indexes come back.
    function bit position_moves(beam_item_t it, output int nx, output int ny);
      bit [31:0] age;
      nx  = held_x;
      ny  = held_y;
      age = it.now - press_time;
      if (it.mode == MODE_WRITE) return 0;
      if (sounding && age < hold) return 0;
      nx = beam_index(it.xb, held_x);
      ny = beam_index(it.yb, held_y);
      if ((nx == NO_BEAM) != (ny == NO_BEAM)) return 0;
      if (nx == held_x && ny == held_y) return 0;
      return 1;
    endfunction

    // Table entry that this sample would read, or none.
    function int lookup_addr(beam_item_t it);
      int nx;
      int ny;
      if (!position_moves(it, nx, ny) || nx == NO_BEAM) return NO_BEAM;
      return table_addr(scale_sel, nx, ny);
    endfunction

    function void note_input(beam_item_t it);
      int          nx;
      int          ny;
      int          addr;
      bit          press;
      bit [7:0]    entry;
      note_event_t ev;
      if (it.mode == MODE_WRITE) begin
        addr          = table_addr(it.es, it.ex, it.ey);
        notes[addr]   = it.en;
        written[addr] = 1;
        return;
      end
      if (!position_moves(it, nx, ny)) return;
      press = 0;
      entry = 0;
      if (nx != NO_BEAM) begin
        entry = notes[table_addr(scale_sel, nx, ny)];
        press = !entry[7];
      end
      if (sounding) begin
        ev.note     = held_note;
        ev.velocity = 0;
        ev.channel  = chan;
        ev.last     = !press;
        owed_events.push_back(ev);
      end
      if (press) begin
        ev.note     = entry[6:0];
        ev.velocity = press_vel;
        ev.channel  = chan;
        ev.last     = 1;
        owed_events.push_back(ev);
        held_note  = entry[6:0];
        press_time = it.now;
      end
      sounding = press;
      held_x   = nx;
      held_y   = ny;
    endfunction

    task report(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(note_event_t got);
      note_event_t want;
      if (owed_events.size() == 0) begin
        report($sformatf("unexpected event note %0d velocity %0d channel %0d last %0d",
                         got.note, got.velocity, got.channel, got.last));
        return;
      end
      want = owed_events.pop_front();
      if (got.note != want.note)
        report($sformatf("note %0d, want %0d", got.note, want.note));
      if (got.velocity != want.velocity)
        report($sformatf("velocity %0d, want %0d", got.velocity, want.velocity));
      if (got.channel != want.channel)
        report($sformatf("channel %0d, want %0d", got.channel, want.channel));
      if (got.last != want.last)
        report($sformatf("last %0d, want %0d", got.last, want.last));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [3:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid;
  logic              in_ready;
  logic              mode;
  logic [7:0]        x_beams;
  logic [7:0]        y_beams;
  logic [31:0]       now_ms;
  logic [1:0]        entry_scale;
  logic [2:0]        entry_x;
  logic [2:0]        entry_y;
  logic signed [7:0] entry_note;
  logic              out_valid;
  logic              out_ready;
  logic [6:0]        note;
  logic [6:0]        velocity;
  logic [3:0]        channel;
  logic              last;

  beam_grid_note_trigger_core dut (.*);

  grid_scoreboard sb;
  bit             no_idle;      // phase without gaps on either side
  bit [31:0]      t_now;        // running sample clock in ms
  int             stall_left;
  int             quiet_cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------
  // Mostly back-to-back, sometimes short gaps, now and then a long one.
  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Valid notes dominate; the rest are the no-note marker or other negatives.
  function bit [7:0] random_note();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 127);
    if (r < 95) return 8'hFF;
    return 8'h80 | $urandom_range(0, 127);
  endfunction

  // Beam pattern for one axis, biased toward playable gestures.
  function bit [7:0] random_beams(int held);
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 8'h01 << $urandom_range(0, 7);
    if (r < 60 && held >= 0) return (8'h01 << held) | $urandom_range(0, 255);
    if (r < 72) return 8'h00;
    if (r < 85) return $urandom_range(0, 255);
    if (held >= 0) return 8'h01 << held;
    return 8'h00;
  endfunction

  // Steps around the hold time hit both sides of the hold check.
  function bit [31:0] time_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, sb.hold + sb.hold / 2 + 8);
    if (r < 90) return $urandom_range(0, 300);
    return $urandom();
  endfunction

  function beam_item_t sample(bit [7:0] xb, bit [7:0] yb, bit [31:0] now);
    beam_item_t it;
    it.mode = MODE_SAMPLE;
    it.xb   = xb;
    it.yb   = yb;
    it.now  = now;
    it.es   = $urandom_range(0, 3);
    it.ex   = $urandom_range(0, 7);
    it.ey   = $urandom_range(0, 7);
    it.en   = $urandom_range(0, 255);
    return it;
  endfunction

  function beam_item_t table_write(bit [1:0] s, bit [2:0] x, bit [2:0] y, bit [7:0] n);
    beam_item_t it;
    it.mode = MODE_WRITE;
    it.xb   = $urandom_range(0, 255);
    it.yb   = $urandom_range(0, 255);
    it.now  = $urandom();
    it.es   = s;
    it.ex   = x;
    it.ey   = y;
    it.en   = n;
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers: every task starts and ends at a falling edge
  // --------------------------------------------------------------------------
  task automatic drive_item(beam_item_t it);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1;
    mode        <= it.mode;
    x_beams     <= it.xb;
    y_beams     <= it.yb;
    now_ms      <= it.now;
    entry_scale <= it.es;
    entry_x     <= it.ex;
    entry_y     <= it.ey;
    entry_note  <= it.en;
    // hold the payload until the transfer
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    @(negedge clk);
  endtask

  // Load the table entry a sample is about to read if it was never written.
  task automatic send_item(beam_item_t it);
    int addr;
    addr = sb.lookup_addr(it);
    if (addr != NO_BEAM && !sb.written[addr])
      drive_item(table_write(2'(addr / (BEAMS * BEAMS)), 3'(addr % BEAMS),
                             3'((addr / BEAMS) % BEAMS), random_note()));
    drive_item(it);
  endtask

  task automatic reg_write(bit [1:0] idx, bit [31:0] val);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel    <= 0;
    penable <= 0;
    @(negedge clk);
  endtask

  // Stop sending until nothing is owed, then let silent items clear the core.
  task automatic drain();
    in_valid <= 0;
    while (sb.owed_events.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic directed();
    // table corners, a zero note, the no-note marker and another negative
    send_item(table_write(0, 0, 0, 8'd60));
    send_item(table_write(0, 7, 7, 8'd127));
    send_item(table_write(0, 3, 5, 8'd0));
    send_item(table_write(0, 1, 1, 8'hFF));
    send_item(table_write(0, 2, 2, 8'h80));
    send_item(table_write(3, 7, 0, 8'd12));
    send_item(sample(8'h01, 8'h01, 32'd1000));       // first press
    send_item(sample(8'h80, 8'h80, 32'd1050));       // held too briefly
    send_item(sample(8'h80, 8'h80, 32'd1100));       // exactly the hold time
    send_item(sample(8'h81, 8'h80, 32'd1300));       // held beam stays broken
    send_item(sample(8'h80, 8'h00, 32'd1400));       // one axis only
    send_item(sample(8'h03, 8'h00, 32'd1500));       // several beams mean none
    send_item(sample(8'h02, 8'h02, 32'd1600));       // entry without a note
    send_item(sample(8'h08, 8'h20, 32'd1700));       // note zero
    send_item(sample(8'h04, 8'h04, 32'd1800));       // negative entry releases
    send_item(sample(8'h00, 8'h00, 32'd1900));
    send_item(sample(8'h01, 8'h01, 32'hFFFF_FFC0));  // press just before wrap
    send_item(sample(8'h80, 8'h80, 32'h0000_0010));  // still held across wrap
    send_item(sample(8'h80, 8'h80, 32'h0000_0024));  // hold met across wrap
    send_item(sample(8'hFF, 8'hFF, 32'h0000_0200));
    send_item(sample(8'hFE, 8'h7F, 32'h0000_0300));
    t_now = 32'h0000_0400;
  endtask

  task automatic random_items(int count);
    beam_item_t it;
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) begin
        it = table_write($urandom_range(0, 3), $urandom_range(0, 7),
                         $urandom_range(0, 7), random_note());
      end else begin
        t_now += time_step();
        if ($urandom_range(0, 9) == 0)
          it = sample(8'h00, 8'h00, t_now);
        else
          it = sample(random_beams(sb.held_x), random_beams(sb.held_y), t_now);
      end
      send_item(it);
    end
  endtask

  // Reprogram all registers on an idle core, then run random traffic.
  task automatic run_phase(int count, bit [1:0] scale, bit [15:0] hold,
                           bit [6:0] vel, bit [3:0] chan, bit busy);
    drain();
    reg_write(REG_SCALE_SELECT, scale);
    reg_write(REG_HOLD_MS, hold);
    reg_write(REG_PRESS_VELOCITY, vel);
    reg_write(REG_EVENT_CHANNEL, chan);
    no_idle = busy;
    random_items(count);
  endtask

  initial begin
    sb          = new();
    no_idle     = 0;
    t_now       = 0;
    rst         = 1;
    psel        = 0;
    penable     = 0;
    pwrite      = 0;
    paddr       = 0;
    pwdata      = 0;
    in_valid    = 0;
    mode        = MODE_SAMPLE;
    x_beams     = 0;
    y_beams     = 0;
    now_ms      = 0;
    entry_scale = 0;
    entry_x     = 0;
    entry_y     = 0;
    entry_note  = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    directed();
    run_phase(140, 2'd3, 16'd0, 7'd1, 4'd15, 0);
    run_phase(100, 2'd1, 16'd65535, 7'd0, 4'd8, 0);   // zero press velocity
    run_phase(140, 2'd0, 16'd100, 7'd127, 4'd0, 1);
    run_phase(140, 2'd2, 16'd1, 7'd64, 4'd3, 0);
    repeat (3)
      run_phase(140, $urandom_range(0, 3), $urandom_range(0, 300),
                $urandom_range(1, 127), $urandom_range(0, 15),
                $urandom_range(0, 3) == 0);

    drain();
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, monitor and watchdog
  // --------------------------------------------------------------------------
  initial begin
    out_ready  = 0;
    stall_left = 0;
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 0;
      stall_left--;
    end else begin
      out_ready  <= 1;
      stall_left = gap_len();
    end
  end

  always @(posedge clk) begin
    note_event_t ev;
    if (!rst && out_valid && out_ready) begin
      ev.note     = note;
      ev.velocity = velocity;
      ev.channel  = channel;
      ev.last     = last;
      sb.check_result(ev);
    end
  end

  // Abort when no transfer happens on either channel for too long.
  initial quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
